@@ hdl/bpl_pkg.sv @@
// bpl_pkg: shared constants for the brickwall peak limiter.
// Default widths and configuration register indexes; no dependencies.
package bpl_pkg;

  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  // release pole reset value in Q0.16, rescaled to the gain format at elaboration
  localparam int RELEASE_RESET_Q16  = 65387;

  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 2'd1;

endpackage

@@ hdl/bpl_ifs.sv @@
// bpl_ifs: valid/ready stream interfaces for sample input and limited output.
// Depends on bpl_pkg for default widths.
interface bpl_in_if
  import bpl_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_start;

  modport source (output valid, sample_in, block_start, input ready);
  modport sink   (input valid, sample_in, block_start, output ready);
endinterface

interface bpl_out_if
  import bpl_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [GAIN_FRAC_BITS:0]       gain_now;
  logic [SAMPLE_BITS-2:0]        peak_level;

  modport source (output valid, sample_out, gain_now, peak_level, input ready);
  modport sink   (input valid, sample_out, gain_now, peak_level, output ready);
endinterface

@@ hdl/bpl_divider.sv @@
// bpl_divider: restoring divider, one quotient bit per cycle, for the attack gain.
// Caller guarantees the quotient fits in GAIN_FRAC_BITS+1 bits. Uses bpl_pkg.
module bpl_divider
  import bpl_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [SAMPLE_BITS+GAIN_FRAC_BITS-2:0]   dividend,
  input  logic [SAMPLE_BITS-1:0]                  divisor,
  output logic                                    done,
  output logic [GAIN_FRAC_BITS:0]                 quotient
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int CW = $clog2(F + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [S-1:0]  rem_r;
  logic [S-1:0]  dvs_r;
  logic [F:0]    low_r;
  logic [F:0]    quo_r;

  logic [S:0]    trial;
  logic          fits;

  assign trial = {rem_r, low_r[F]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(F);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // high part of the dividend is below the divisor, so only F+1 steps remain
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= S'(dividend[S+F-2:F+1]);
      low_r <= dividend[F:0];
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      low_r <= {low_r[F-1:0], 1'b0};
      if (fits) begin
        rem_r <= S'(trial - {1'b0, dvs_r});
        quo_r <= {quo_r[F-1:0], 1'b1};
      end else begin
        rem_r <= trial[S-1:0];
        quo_r <= {quo_r[F-1:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/brickwall_peak_limiter.sv @@
// brickwall_peak_limiter: per-sample gain limiter with one shared multiplier and a serial divider.
// Path from transfer to result: MUL, ATK, DIV on an attack, REL, REL2 when the release step runs,
// then APP and FIN into the output register; an attack always leaves a release step to do.
// A new sample is taken only in idle, once the last one is through; the attack divider is the
// slowest path, and a stalled output holds the last state until the output register frees up.
// Synchronous active-low reset: unity gain, zero peak, registers at their reset values.
module brickwall_peak_limiter
  import bpl_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
  localparam int CFGW = (SAMPLE_BITS - 1 > GAIN_FRAC_BITS) ? SAMPLE_BITS - 1 : GAIN_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  bpl_in_if.sink                  in_if,
  bpl_out_if.source               out_if,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFGW-1:0]         cfg_wdata
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int MW = (S > F) ? S : F;
  localparam int PW = MW + F + 1;
  localparam int AW = 2 * F + 1;
  localparam logic [F:0] UNITY = {1'b1, {F{1'b0}}};
  localparam int REL_RST = (F >= 16) ? (RELEASE_RESET_Q16 << (F - 16))
                                     : (RELEASE_RESET_Q16 >> (16 - F));

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ATK, S_DIV, S_REL, S_REL2, S_APP, S_FIN
  } state_t;

  state_t       state_r;
  logic [S-2:0] ceil_r;
  logic [F-1:0] coeff_r;
  logic [F:0]   gain_r;
  logic [S-2:0] peak_r;
  logic [S-1:0] mag_r;
  logic         neg_r;
  logic [PW-1:0] prod_r;

  logic           out_valid_r;
  logic [S-1:0]   out_sample_r;
  logic [F:0]     out_gain_r;
  logic [S-2:0]   out_peak_r;

  logic           in_xfer;
  logic [S-1:0]   mag_in;
  logic [MW-1:0]  op_a;
  logic [PW-1:0]  prod_nxt;
  logic [S+F-2:0] ceil_scaled;
  logic           attack;
  logic           div_start;
  logic           div_done;
  logic [F:0]     div_quo;
  logic [AW-1:0]  acc;
  logic [F:0]     gain_rel_nxt;
  logic [MW:0]    ymag_full;
  logic [S-2:0]   ymag;
  logic           out_free;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  // two's complement magnitude; the most negative code maps to 2^(S-1) by itself
  assign mag_in = in_if.sample_in[S-1] ? S'(~in_if.sample_in + 1'b1) : S'(in_if.sample_in);

  assign op_a     = (state_r == S_REL) ? MW'(coeff_r) : MW'(mag_r);
  assign prod_nxt = PW'(op_a) * PW'(gain_r);

  assign ceil_scaled = {ceil_r, {F{1'b0}}};
  assign attack      = prod_r > PW'(ceil_scaled);
  assign div_start   = (state_r == S_ATK) && attack;

  assign acc          = AW'(prod_r) + (AW'(UNITY - {1'b0, coeff_r}) << F);
  assign gain_rel_nxt = acc[AW-1:F];

  assign ymag_full = prod_r[PW-1:F];
  assign ymag      = (ymag_full > (MW+1)'(ceil_r)) ? ceil_r : ymag_full[S-2:0];
  assign out_free  = !out_valid_r || out_if.ready;

  bpl_divider #(
    .SAMPLE_BITS   (S),
    .GAIN_FRAC_BITS(F)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(ceil_scaled),
    .divisor (mag_r),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= '1;
      coeff_r <= F'(REL_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CEILING: ceil_r  <= cfg_wdata[S-2:0];
        REG_RELEASE: coeff_r <= cfg_wdata[F-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= UNITY;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_if.block_start) begin
              gain_r <= UNITY;
              peak_r <= '0;
            end
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_ATK;
        S_ATK:  state_r <= attack ? S_DIV : S_REL;
        S_DIV: begin
          if (div_done) begin
            gain_r  <= div_quo;
            state_r <= S_REL;
          end
        end
        S_REL:  state_r <= (gain_r < UNITY) ? S_REL2 : S_APP;
        S_REL2: begin
          gain_r  <= gain_rel_nxt;
          state_r <= S_APP;
        end
        S_APP:  state_r <= S_FIN;
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            if (ymag > peak_r) begin
              peak_r <= ymag;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r <= mag_in;
      neg_r <= in_if.sample_in[S-1];
    end
    if (state_r == S_MUL || state_r == S_APP || (state_r == S_REL && gain_r < UNITY)) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_FIN && out_free) begin
      out_sample_r <= neg_r ? S'(~{1'b0, ymag} + 1'b1) : {1'b0, ymag};
      out_gain_r   <= gain_r;
      out_peak_r   <= (ymag > peak_r) ? ymag : peak_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.gain_now   = out_gain_r;
  assign out_if.peak_level = out_peak_r;

  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= UNITY)
    else $error("gain above unity");

  a_div_quo: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV && div_quo < gain_r))
    else $error("attack quotient not below current gain");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_if.ready) |=> (state_r == S_FIN && out_valid_r))
    else $error("result overwrote a pending output");

  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !(in_xfer && in_if.block_start)) |=> peak_r >= $past(peak_r))
    else $error("peak decreased without block start");

  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_if.ready)
    else $error("input taken while busy");

endmodule
